>>> rtl/sem_pkg.sv
package sem_pkg;

    localparam int MAX_WIDTH_DEF = 2048;

    localparam int CFG_WIDTH_W  = 12;
    localparam int CFG_HEIGHT_W = 16;
    localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RST  = 12'd640;
    localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RST = 16'd480;

    localparam logic [20:0] SUM_SAT = 21'd65025;
    localparam logic [7:0]  MAG_MAX = 8'd255;

    typedef enum logic {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [7:0] chan0;
        logic [7:0] chan1;
        logic [7:0] chan2;
        logic       pad;
    } t_in;

    typedef struct packed {
        logic       out_valid;
        logic [7:0] res0;
        logic [7:0] res1;
        logic [7:0] res2;
        logic       frame_end;
    } t_out;

    typedef struct packed {
        logic       capture;
        logic       shift;
        logic       grad;
        logic       square;
        logic       root;
        logic [2:0] step;
        logic       load;
        logic       valid;
        logic       interior;
        logic       last;
    } t_cmd;

    typedef struct packed {
        logic blocked;
    } t_sts;

endpackage

>>> rtl/sem_cfg.sv
module sem_cfg
    import sem_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [2:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    output logic [CFG_WIDTH_W-1:0]  o_width,
    output logic [CFG_HEIGHT_W-1:0] o_height
);

    logic [CFG_WIDTH_W-1:0]  r_width;
    logic [CFG_HEIGHT_W-1:0] r_height;
    t_reg_idx                idx;

    assign idx = t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
        end else if (psel && penable && pwrite) begin
            unique case (idx)
                REG_WIDTH:  r_width  <= pwdata[CFG_WIDTH_W-1:0];
                REG_HEIGHT: r_height <= pwdata[CFG_HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_WIDTH:  prdata = {{(32-CFG_WIDTH_W){1'b0}}, r_width};
            REG_HEIGHT: prdata = {{(32-CFG_HEIGHT_W){1'b0}}, r_height};
            default:    prdata = '0;
        endcase
    end

    assign pready   = 1'b1;
    assign o_width  = r_width;
    assign o_height = r_height;

endmodule

>>> rtl/sem_ctrl.sv
module sem_ctrl
    import sem_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [CFG_WIDTH_W-1:0]       i_width,
    input  logic [CFG_HEIGHT_W-1:0]      i_height,
    input  t_sts                         i_sts,
    output t_cmd                         o_cmd,
    output logic [$clog2(MAX_WIDTH)-1:0] o_addr
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int XW = (WW > CFG_WIDTH_W) ? WW + 1 : CFG_WIDTH_W + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_GRAD,
        S_SQR,
        S_ROOT,
        S_DONE
    } t_state;

    t_state          r_state;
    logic [2:0]      r_step;
    logic [CW-1:0]   r_in_col;
    logic [15:0]     r_in_row;
    logic [CW-1:0]   r_out_col;
    logic [15:0]     r_out_row;
    logic            r_valid;
    logic            r_interior;
    logic            r_last;

    logic [XW-1:0]   w_ext;
    logic [XW-1:0]   w;
    logic [16:0]     h;
    logic [XW-1:0]   in_col_inc;
    logic [XW-1:0]   out_col_inc;
    logic [16:0]     out_row_inc;
    logic            n_valid;
    logic            n_interior;
    logic            n_last;

    // effective frame size, clamped into the legal range
    always_comb begin
        w_ext = XW'(i_width);
        if (w_ext == '0)
            w = XW'(1);
        else if (w_ext > XW'(MAX_WIDTH))
            w = XW'(MAX_WIDTH);
        else
            w = w_ext;
        h = (i_height == '0) ? 17'd1 : {1'b0, i_height};
    end

    always_comb begin
        in_col_inc  = XW'(r_in_col) + XW'(1);
        out_col_inc = XW'(r_out_col) + XW'(1);
        out_row_inc = {1'b0, r_out_row} + 17'd1;
        n_valid     = (r_in_row >= 16'd2) || (r_in_row == 16'd1 && r_in_col != '0);
        n_interior  = (r_out_row != '0) && (out_row_inc < h) &&
                      (r_out_col != '0) && (out_col_inc < w) && (r_in_col != '0);
        n_last      = (out_row_inc >= h) && (out_col_inc >= w);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_step     <= '0;
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_valid    <= 1'b0;
            r_interior <= 1'b0;
            r_last     <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid)
                        r_state <= S_READ;
                end
                S_READ: begin
                    r_valid    <= n_valid;
                    r_interior <= n_interior;
                    r_last     <= n_last;
                    if (n_valid && n_last) begin
                        r_in_col  <= '0;
                        r_in_row  <= '0;
                        r_out_col <= '0;
                        r_out_row <= '0;
                    end else begin
                        if (in_col_inc >= w) begin
                            r_in_col <= '0;
                            if (r_in_row != 16'hFFFF)
                                r_in_row <= r_in_row + 16'd1;
                        end else begin
                            r_in_col <= in_col_inc[CW-1:0];
                        end
                        if (n_valid) begin
                            if (out_col_inc >= w) begin
                                r_out_col <= '0;
                                r_out_row <= out_row_inc[15:0];
                            end else begin
                                r_out_col <= out_col_inc[CW-1:0];
                            end
                        end
                    end
                    r_state <= S_GRAD;
                end
                S_GRAD: r_state <= S_SQR;
                S_SQR: begin
                    r_step  <= '0;
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    r_step <= r_step + 3'd1;
                    if (r_step == 3'd7)
                        r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!i_sts.blocked)
                        r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.step     = r_step;
        o_cmd.valid    = r_valid;
        o_cmd.interior = r_interior;
        o_cmd.last     = r_last;
        unique case (r_state)
            S_IDLE:  o_cmd.capture = i_in_valid;
            S_READ:  o_cmd.shift   = 1'b1;
            S_GRAD:  o_cmd.grad    = 1'b1;
            S_SQR:   o_cmd.square  = 1'b1;
            S_ROOT:  o_cmd.root    = 1'b1;
            S_DONE:  o_cmd.load    = !i_sts.blocked;
            default: ;
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign o_addr     = r_in_col;

endmodule

>>> rtl/sem_dp.sv
module sem_dp
    import sem_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_in                          i_in_data,
    input  t_cmd                         i_cmd,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_addr,
    output t_sts                         o_sts,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output t_out                         o_out_data
);

    logic [23:0] r_mem_upper [MAX_WIDTH];
    logic [23:0] r_mem_middle[MAX_WIDTH];
    logic [23:0] r_rd_upper;
    logic [23:0] r_rd_middle;
    logic [23:0] r_px;
    logic [23:0] r_win[9];
    logic [23:0] r_center;

    logic signed [10:0] r_gx[3];
    logic signed [10:0] r_gy[3];
    logic [20:0]        r_sum[3];
    logic [7:0]         r_root[3];

    logic               r_out_vld;
    t_out               r_out;

    logic signed [10:0] n_gx[3];
    logic signed [10:0] n_gy[3];
    logic [20:0]        n_sum[3];
    logic [7:0]         n_root[3];
    logic [7:0]         res[3];
    logic [7:0]         rbit;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_px        <= i_in_data.pad ? 24'd0 :
                           {i_in_data.chan2, i_in_data.chan1, i_in_data.chan0};
            r_rd_upper  <= r_mem_upper[i_addr];
            r_rd_middle <= r_mem_middle[i_addr];
        end
        if (i_cmd.shift) begin
            r_mem_upper[i_addr]  <= r_rd_middle;
            r_mem_middle[i_addr] <= r_px;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 9; i++)
                r_win[i] <= '0;
        end else if (i_cmd.shift) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r*3]   <= r_win[r*3+1];
                r_win[r*3+1] <= r_win[r*3+2];
            end
            r_win[2] <= r_rd_upper;
            r_win[5] <= r_rd_middle;
            r_win[8] <= r_px;
        end
    end

    // border pixels pass the middle-right tap as it stood before the shift
    always_ff @(posedge i_clk) begin
        if (i_cmd.shift)
            r_center <= r_win[5];
    end

    always_comb begin
        logic [10:0] xp, xn, yp, yn;
        logic [7:0]  p[9];
        logic signed [21:0] sx, sy;
        logic [7:0]  t;
        logic [15:0] tt;
        rbit = 8'h80 >> i_cmd.step;
        for (int ch = 0; ch < 3; ch++) begin
            for (int i = 0; i < 9; i++)
                p[i] = r_win[i][8*ch +: 8];
            xp = {3'b0, p[2]} + {2'b0, p[5], 1'b0} + {3'b0, p[8]};
            xn = {3'b0, p[0]} + {2'b0, p[3], 1'b0} + {3'b0, p[6]};
            yp = {3'b0, p[6]} + {2'b0, p[7], 1'b0} + {3'b0, p[8]};
            yn = {3'b0, p[0]} + {2'b0, p[1], 1'b0} + {3'b0, p[2]};
            n_gx[ch] = $signed(xp - xn);
            n_gy[ch] = $signed(yp - yn);
            sx = r_gx[ch] * r_gx[ch];
            sy = r_gy[ch] * r_gy[ch];
            n_sum[ch] = sx[20:0] + sy[20:0];
            t  = r_root[ch] | rbit;
            tt = t * t;
            n_root[ch] = ({5'b0, tt} <= r_sum[ch]) ? t : r_root[ch];
            if (!i_cmd.valid)
                res[ch] = '0;
            else if (!i_cmd.interior)
                res[ch] = r_center[8*ch +: 8];
            else if (r_sum[ch] >= SUM_SAT)
                res[ch] = MAG_MAX;
            else
                res[ch] = r_root[ch];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int ch = 0; ch < 3; ch++) begin
            if (i_cmd.grad) begin
                r_gx[ch] <= n_gx[ch];
                r_gy[ch] <= n_gy[ch];
            end
            if (i_cmd.square) begin
                r_sum[ch]  <= n_sum[ch];
                r_root[ch] <= '0;
            end else if (i_cmd.root) begin
                r_root[ch] <= n_root[ch];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out.out_valid <= i_cmd.valid;
            r_out.res0      <= res[0];
            r_out.res1      <= res[1];
            r_out.res2      <= res[2];
            r_out.frame_end <= i_cmd.valid && i_cmd.last;
        end
    end

    assign o_sts.blocked = r_out_vld && i_out_stall;
    assign o_out_valid   = r_out_vld;
    assign o_out_data    = r_out;

endmodule

>>> rtl/sobel_edge_magnitude_3x3_unit.sv
// sequence: an accepted input goes through read, gradient and square steps and the eight-step
//   square-root iteration, and the done state then loads the result into the output register;
//   the input stays stalled until that load, which waits while the output is stalled
// reset: synchronous active-low clears the sequencer, counters, window and output valid;
//   the line stores are not cleared and need no clearing pass
module sobel_edge_magnitude_3x3_unit
    import sem_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out        o_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [CFG_WIDTH_W-1:0]       width;
    logic [CFG_HEIGHT_W-1:0]      height;
    t_cmd                         cmd;
    t_sts                         sts;
    logic [$clog2(MAX_WIDTH)-1:0] addr;

    sem_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_width (width),
        .o_height(height)
    );

    sem_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_width   (width),
        .i_height  (height),
        .i_sts     (sts),
        .o_cmd     (cmd),
        .o_addr    (addr)
    );

    sem_dp #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .i_addr     (addr),
        .o_sts      (sts),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

endmodule

>>> rtl/sem_chk.sv
module sem_chk
    import sem_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall,
    input t_out o_out_data,
    input logic pready
);

    // one item at a time: an accept always closes the input side next cycle
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted while previous item still in work");

    a_idle_result_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.out_valid) |->
        (o_out_data.res0 == 8'd0 && o_out_data.res1 == 8'd0 &&
         o_out_data.res2 == 8'd0 && !o_out_data.frame_end))
        else $error("non-pixel result carries data");

    a_frame_end_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.frame_end) |-> o_out_data.out_valid)
        else $error("frame end on a non-pixel result");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("pready dropped");

endmodule

bind sobel_edge_magnitude_3x3_unit sem_chk u_sem_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_stall (o_in_stall),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out_data (o_out_data),
    .pready     (pready)
);

>>> tb/sobel_edge_magnitude_3x3_unit_test.sv
`timescale 1ns / 1ps
module sobel_edge_magnitude_3x3_unit_test;
    import sem_pkg::*;

    localparam int     LINE_DEPTH   = MAX_WIDTH_DEF;
    localparam int     SETTLE_CYC   = 20;
    localparam longint CYCLE_LIMIT  = 3000000;
    localparam int     RANDOM_ITEMS = 1050;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in         i_in_data;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out        o_out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    sobel_edge_magnitude_3x3_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #2 i_clk = ~i_clk;

    // predictor state
    logic [11:0] img_w;
    logic [15:0] img_h;
    logic [23:0] row_above2 [LINE_DEPTH];
    logic [23:0] row_above1 [LINE_DEPTH];
    logic [23:0] win [9];
    int unsigned in_col, in_row, out_col, out_row;

    t_out   pixel_q [$];
    int     err_count;
    int     items_sent;
    int     results_seen;
    int     frames_seen;
    longint cycles;
    bit     in_idle;
    bit     out_idle;

    typedef struct {
        logic [7:0] c0;
        logic [7:0] c1;
        logic [7:0] c2;
        logic       pad;
        bit         no_pixel;
    } t_dir_row;

    // 3x3 frame with strong edges, flush with a real pixel in it, extra pads,
    // then a partial frame with a pad inside it
    t_dir_row dir_rows [0:21] = '{
        '{8'd0,   8'd0,   8'd255, 1'b0, 1'b1},
        '{8'd0,   8'd0,   8'd0,   1'b0, 1'b1},
        '{8'd255, 8'd0,   8'd255, 1'b0, 1'b1},
        '{8'd0,   8'd0,   8'd0,   1'b0, 1'b1},
        '{8'd77,  8'd255, 8'd1,   1'b0, 1'b0},
        '{8'd255, 8'd0,   8'd128, 1'b0, 1'b0},
        '{8'd0,   8'd255, 8'd255, 1'b0, 1'b0},
        '{8'd0,   8'd255, 8'd0,   1'b0, 1'b0},
        '{8'd255, 8'd255, 8'd254, 1'b0, 1'b0},
        '{8'd255, 8'd255, 8'd255, 1'b1, 1'b0},
        '{8'd170, 8'd85,  8'd170, 1'b0, 1'b0},
        '{8'd255, 8'd0,   8'd255, 1'b1, 1'b0},
        '{8'd0,   8'd0,   8'd0,   1'b1, 1'b0},
        '{8'd0,   8'd0,   8'd0,   1'b1, 1'b0},
        '{8'd1,   8'd2,   8'd3,   1'b1, 1'b0},
        '{8'd255, 8'd255, 8'd255, 1'b0, 1'b0},
        '{8'd128, 8'd127, 8'd64,  1'b0, 1'b0},
        '{8'd200, 8'd7,   8'd255, 1'b1, 1'b0},
        '{8'd0,   8'd255, 8'd0,   1'b0, 1'b0},
        '{8'd255, 8'd0,   8'd255, 1'b0, 1'b0},
        '{8'd9,   8'd99,  8'd199, 1'b0, 1'b0},
        '{8'd255, 8'd255, 8'd0,   1'b0, 1'b0}
    };

    function automatic int unsigned eff_w();
        if (img_w == 0) return 1;
        if (img_w > LINE_DEPTH) return LINE_DEPTH;
        return img_w;
    endfunction

    function automatic int unsigned eff_h();
        return (img_h == 0) ? 1 : img_h;
    endfunction

    function automatic logic [7:0] edge_mag(int ch);
        int          p [9];
        int          gx, gy;
        int unsigned s, r, t;
        for (int i = 0; i < 9; i++) p[i] = win[i][8*ch +: 8];
        gx = (p[2] + 2 * p[5] + p[8]) - (p[0] + 2 * p[3] + p[6]);
        gy = (p[6] + 2 * p[7] + p[8]) - (p[0] + 2 * p[1] + p[2]);
        s = gx * gx + gy * gy;
        if (s >= 65025) return MAG_MAX;
        r = 0;
        for (int b = 128; b > 0; b >>= 1) begin
            t = r + b;
            if (t * t <= s) r = t;
        end
        return r[7:0];
    endfunction

    function automatic t_out predict_pixel(t_in d);
        int unsigned w, h, c, idx;
        logic [23:0] px, pre, center;
        bit          valid, interior, last;
        t_out        o;
        w = eff_w();
        h = eff_h();
        c = in_col;
        idx = (c < LINE_DEPTH) ? c : LINE_DEPTH - 1;
        px = d.pad ? 24'd0 : {d.chan2, d.chan1, d.chan0};
        pre = win[5];
        for (int r = 0; r < 3; r++) begin
            win[r*3]   = win[r*3+1];
            win[r*3+1] = win[r*3+2];
        end
        win[2] = row_above2[idx];
        win[5] = row_above1[idx];
        win[8] = px;
        row_above2[idx] = row_above1[idx];
        row_above1[idx] = px;
        valid = in_row >= 2 || (in_row == 1 && c >= 1);
        if (c + 1 >= w) begin
            in_col = 0;
            if (in_row < 65535) in_row++;
        end else begin
            in_col = c + 1;
        end
        o = '0;
        if (!valid) return o;
        center = (c == 0) ? pre : win[4];
        interior = out_row >= 1 && out_row + 1 < h && out_col >= 1 && out_col + 1 < w
                   && c != 0;
        last = out_row + 1 >= h && out_col + 1 >= w;
        o.out_valid = 1'b1;
        o.res0 = interior ? edge_mag(0) : center[7:0];
        o.res1 = interior ? edge_mag(1) : center[15:8];
        o.res2 = interior ? edge_mag(2) : center[23:16];
        if (last) begin
            o.frame_end = 1'b1;
            in_col = 0;
            in_row = 0;
            out_col = 0;
            out_row = 0;
        end else if (out_col + 1 >= w) begin
            out_col = 0;
            out_row = (out_row + 1) & 16'hFFFF;
        end else begin
            out_col++;
        end
        return o;
    endfunction

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 3))
            0: return 8'd0;
            1: return 8'd255;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    function automatic t_in rand_pixel();
        t_in d;
        d.chan0 = rand_byte();
        d.chan1 = rand_byte();
        d.chan2 = rand_byte();
        d.pad = 1'b0;
        return d;
    endfunction

    task automatic send_item(t_in d, bit typed, t_out typed_exp);
        t_out p;
        int   gap;
        i_in_valid <= 1'b1;
        i_in_data <= d;
        do @(posedge i_clk); while (o_in_stall);
        p = predict_pixel(d);
        pixel_q.push_back(typed ? typed_exp : p);
        items_sent++;
        gap = in_idle ? $urandom_range(0, 12) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_pad(bit real_px);
        t_in d;
        d = rand_pixel();
        d.pad = !real_px;
        send_item(d, 1'b0, '0);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pixel_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx r, logic [31:0] v);
        logic [31:0] want;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {r, 2'b00};
        pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (r == REG_WIDTH) begin
            img_w = v[11:0];
            want = {20'd0, img_w};
        end else begin
            img_h = v[15:0];
            want = {16'd0, img_h};
        end
        if (prdata !== want) begin
            $display("%0t: register %s read back: expected %h, got %h",
                     $time, r.name(), want, prdata);
            err_count++;
        end
    endtask

    task automatic set_size(logic [31:0] w, logic [31:0] h);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
    endtask

    task automatic run_frame(bit noisy);
        int unsigned n;
        t_in         d;
        n = eff_w() * eff_h();
        for (int unsigned i = 0; i < n; i++) begin
            d = rand_pixel();
            if (noisy && $urandom_range(0, 15) == 0) d.pad = 1'b1;
            send_item(d, 1'b0, '0);
        end
        for (int unsigned i = 0; i <= eff_w(); i++)
            send_pad(noisy && $urandom_range(0, 7) == 0);
        if (noisy && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) send_pad(1'b0);
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
            err_count++;
        end
    endtask

    // result side: random stall per item, compare each accepted item
    initial begin
        t_out e;
        int   n;
        i_out_stall <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            n = out_idle ? $urandom_range(0, 12) : 0;
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!(o_out_valid && !i_out_stall));
            results_seen++;
            if (pixel_q.size() == 0) begin
                $display("%0t: unexpected item %h", $time, o_out_data);
                err_count++;
            end else begin
                e = pixel_q.pop_front();
                check_field("out_valid", e.out_valid, o_out_data.out_valid);
                check_field("res0", e.res0, o_out_data.res0);
                check_field("res1", e.res1, o_out_data.res1);
                check_field("res2", e.res2, o_out_data.res2);
                check_field("frame_end", e.frame_end, o_out_data.frame_end);
                if (o_out_data.frame_end) frames_seen++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout with %0d items outstanding", pixel_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        t_in         d;
        int          rand_start;
        int unsigned wsel [8];
        int unsigned hsel [7];
        wsel = '{0, 1, 2, 3, 4, 5, 8, 13};
        hsel = '{0, 1, 2, 3, 4, 5, 7};
        cycles = 0;
        err_count = 0;
        items_sent = 0;
        results_seen = 0;
        frames_seen = 0;
        in_idle = 1'b1;
        out_idle = 1'b1;
        img_w = WIDTH_RST;
        img_h = HEIGHT_RST;
        foreach (win[i]) win[i] = '0;
        foreach (row_above2[i]) row_above2[i] = '0;
        foreach (row_above1[i]) row_above1[i] = '0;
        in_col = 0;
        in_row = 0;
        out_col = 0;
        out_row = 0;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // clean frame at the widest random size fills both line stores
        set_size(13, 2);
        run_frame(1'b0);
        wait_idle();

        set_size(3, 3);
        foreach (dir_rows[i]) begin
            d.chan0 = dir_rows[i].c0;
            d.chan1 = dir_rows[i].c1;
            d.chan2 = dir_rows[i].c2;
            d.pad = dir_rows[i].pad;
            // the first row and the first pixel of the second row give no pixel, all fields zero
            send_item(d, dir_rows[i].no_pixel, '0);
        end
        wait_idle();

        // all-ones register values read back cut to the field width
        set_size(32'hFFFF_FFFF, 32'hFFFF_FFFF);

        // tallest frame, cut short by a height change while counters run
        set_size(2, 32'h0000_FFFF);
        repeat (11) send_item(rand_pixel(), 1'b0, '0);
        wait_idle();
        write_reg(REG_HEIGHT, 3);
        run_frame(1'b0);
        wait_idle();

        rand_start = items_sent;
        while (items_sent - rand_start < RANDOM_ITEMS) begin
            in_idle = $urandom_range(0, 3) != 0;
            out_idle = $urandom_range(0, 3) != 0;
            set_size(wsel[$urandom_range(0, 7)], hsel[$urandom_range(0, 6)]);
            repeat ($urandom_range(1, 3)) run_frame($urandom_range(0, 3) == 0);
            wait_idle();
        end

        i_in_valid <= 1'b0;
        while (pixel_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
        $display("sent %0d items, checked %0d results, %0d frames completed",
                 items_sent, results_seen, frames_seen);
        $display("frame sizes from 1x1 to 13 wide, register masking, pads, flush noise, stalls");
        if (err_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
